// ----- design/xcr_pkg.sv -----
`default_nettype none

package xcr_pkg;

    localparam int PACKET_MAX = 1024;
    localparam int ADDR_W     = $clog2(PACKET_MAX);
    localparam int COUNT_W    = ADDR_W + 1;

    localparam logic [COUNT_W-1:0] SHORT_SIZE = COUNT_W'(128);
    localparam logic [COUNT_W-1:0] LONG_SIZE  = COUNT_W'(PACKET_MAX);

    // control characters on the line
    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CAN = 8'h18;
    localparam logic [7:0] B_C   = 8'h43;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] RETRY_RESET = 16'd10;

    typedef enum logic [2:0] {
        OP_REQUEST = 3'd0,
        OP_RX      = 3'd1,
        OP_TIMEOUT = 3'd2,
        OP_READ    = 3'd3,
        OP_ABORT   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_PACKET = 2'd1,
        EV_END    = 2'd2,
        EV_ERROR  = 2'd3
    } ev_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HEAD = 3'd1,
        PH_SEQ  = 3'd2,
        PH_CMP  = 3'd3,
        PH_DATA = 3'd4,
        PH_CRCH = 3'd5,
        PH_CRCL = 3'd6
    } phase_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [7:0]         rx_byte;
        logic [COUNT_W-1:0] byte_limit;
        logic [ADDR_W-1:0]  read_index;
    } xcr_in_t;

    typedef struct packed {
        logic               tx_valid;
        logic [7:0]         tx_byte;
        logic [1:0]         event_res;
        logic [COUNT_W-1:0] count;
        logic [7:0]         read_data;
        logic               last;
    } xcr_out_t;

    // final result of an item; dbl puts a plain CAN in front of it
    typedef struct packed {
        logic               tx_valid;
        logic [7:0]         tx_byte;
        logic [1:0]         event_res;
        logic [COUNT_W-1:0] count;
        logic               dbl;
        logic               rd_ok;
    } xcr_rec_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              res_v;
        xcr_rec_t          rec;
    } xcr_act_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/xcr_frame.sv -----
`default_nettype none

module xcr_frame
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            acc,
    input  wire xcr_pkg::xcr_in_t item,
    input  wire logic            cfg_we,
    input  wire logic [15:0]     cfg_data,
    output xcr_pkg::xcr_act_t    act
);

    xcr_pkg::phase_t                 phase_reg, phase_next;
    logic                            link_reg, link_next;
    logic [7:0]                      seq_reg, seq_next;
    logic [7:0]                      got_seq_reg, got_seq_next;
    logic [15:0]                     retries_reg, retries_next;
    logic                            long_reg, long_next;
    logic [xcr_pkg::COUNT_W-1:0]     bc_reg, bc_next;
    logic [15:0]                     crc_reg, crc_next;
    logic [7:0]                      rcrc_hi_reg, rcrc_hi_next;
    logic [xcr_pkg::COUNT_W-1:0]     limit_reg, limit_next;
    logic [15:0]                     retry_limit_reg;

    logic [xcr_pkg::COUNT_W-1:0]     size;
    logic [xcr_pkg::COUNT_W-1:0]     bc_inc;
    logic [15:0]                     retries_dec;
    logic                            err, fail;

    assign size        = long_reg ? xcr_pkg::LONG_SIZE : xcr_pkg::SHORT_SIZE;
    assign bc_inc      = bc_reg + xcr_pkg::COUNT_W'(1);
    assign retries_dec = retries_reg - 16'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        link_next    = link_reg;
        seq_next     = seq_reg;
        got_seq_next = got_seq_reg;
        retries_next = retries_reg;
        long_next    = long_reg;
        bc_next      = bc_reg;
        crc_next     = crc_reg;
        rcrc_hi_next = rcrc_hi_reg;
        limit_next   = limit_reg;
        act          = '0;
        err          = 1'b0;
        fail         = 1'b0;

        case (item.operation)
            xcr_pkg::OP_REQUEST:
            begin
                if (item.byte_limit == '0)
                    limit_next = xcr_pkg::COUNT_W'(1);
                else if (item.byte_limit > xcr_pkg::LONG_SIZE)
                    limit_next = xcr_pkg::LONG_SIZE;
                else
                    limit_next = item.byte_limit;
                seq_next     = link_reg ? seq_reg + 8'd1 : 8'd1;
                retries_next = (retry_limit_reg == '0) ? 16'd1 : retry_limit_reg;
                bc_next      = '0;
                phase_next   = xcr_pkg::PH_HEAD;
                act.res_v        = 1'b1;
                act.rec.tx_valid = 1'b1;
                act.rec.tx_byte  = link_reg ? xcr_pkg::B_ACK : xcr_pkg::B_C;
            end
            xcr_pkg::OP_RX:
            begin
                unique case (phase_reg)
                    xcr_pkg::PH_HEAD:
                    begin
                        retries_next = retries_dec;
                        if (item.rx_byte == xcr_pkg::B_SOH || item.rx_byte == xcr_pkg::B_STX)
                        begin
                            long_next  = (item.rx_byte == xcr_pkg::B_STX);
                            crc_next   = '0;
                            bc_next    = '0;
                            phase_next = xcr_pkg::PH_SEQ;
                        end
                        else if (item.rx_byte == xcr_pkg::B_EOT)
                        begin
                            link_next  = 1'b0;
                            phase_next = xcr_pkg::PH_IDLE;
                            bc_next    = '0;
                            act.res_v         = 1'b1;
                            act.rec.tx_valid  = 1'b1;
                            act.rec.tx_byte   = xcr_pkg::B_ACK;
                            act.rec.event_res = xcr_pkg::EV_END;
                        end
                        else
                            err = 1'b1;
                    end
                    xcr_pkg::PH_SEQ:
                    begin
                        got_seq_next = item.rx_byte;
                        phase_next   = xcr_pkg::PH_CMP;
                    end
                    xcr_pkg::PH_CMP:
                    begin
                        if (got_seq_reg == seq_reg && item.rx_byte == ~seq_reg)
                            phase_next = xcr_pkg::PH_DATA;
                        else
                            fail = 1'b1;
                    end
                    xcr_pkg::PH_DATA:
                    begin
                        act.wr_en   = 1'b1;
                        act.wr_addr = bc_reg[xcr_pkg::ADDR_W-1:0];
                        act.wr_data = item.rx_byte;
                        crc_next    = xcr_pkg::crc_byte(crc_reg, item.rx_byte);
                        bc_next     = bc_inc;
                        if (bc_inc >= size)
                            phase_next = xcr_pkg::PH_CRCH;
                    end
                    xcr_pkg::PH_CRCH:
                    begin
                        rcrc_hi_next = item.rx_byte;
                        phase_next   = xcr_pkg::PH_CRCL;
                    end
                    xcr_pkg::PH_CRCL:
                    begin
                        if ({rcrc_hi_reg, item.rx_byte} == crc_reg)
                        begin
                            bc_next    = (limit_reg < size) ? limit_reg : size;
                            link_next  = 1'b1;
                            phase_next = xcr_pkg::PH_IDLE;
                            act.res_v         = 1'b1;
                            act.rec.event_res = xcr_pkg::EV_PACKET;
                            act.rec.count     = (limit_reg < size) ? limit_reg : size;
                        end
                        else
                            fail = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            xcr_pkg::OP_TIMEOUT:
            begin
                if (phase_reg == xcr_pkg::PH_HEAD)
                begin
                    retries_next = retries_dec;
                    err          = (retries_dec == '0);
                end
                else if (phase_reg != xcr_pkg::PH_IDLE)
                    fail = 1'b1;
            end
            xcr_pkg::OP_READ:
            begin
                act.res_v     = 1'b1;
                act.rec.rd_ok = ({1'b0, item.read_index} < bc_reg);
            end
            xcr_pkg::OP_ABORT:
            begin
                phase_next = xcr_pkg::PH_IDLE;
                if (link_reg)
                begin
                    link_next        = 1'b0;
                    bc_next          = '0;
                    act.res_v        = 1'b1;
                    act.rec.tx_valid = 1'b1;
                    act.rec.tx_byte  = xcr_pkg::B_CAN;
                    act.rec.dbl      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // failed attempt: NAK while retries remain
        if (fail)
        begin
            if (retries_reg != '0)
            begin
                phase_next = xcr_pkg::PH_HEAD;
                bc_next    = '0;
                act.res_v        = 1'b1;
                act.rec.tx_valid = 1'b1;
                act.rec.tx_byte  = xcr_pkg::B_NAK;
            end
            else
                err = 1'b1;
        end

        if (err)
        begin
            link_next  = 1'b0;
            phase_next = xcr_pkg::PH_IDLE;
            bc_next    = '0;
            act.res_v         = 1'b1;
            act.rec.tx_valid  = link_reg;
            act.rec.tx_byte   = link_reg ? xcr_pkg::B_CAN : 8'h00;
            act.rec.event_res = xcr_pkg::EV_ERROR;
            act.rec.dbl       = link_reg;
        end

        if (!acc)
            act = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            retry_limit_reg <= xcr_pkg::RETRY_RESET;
        else if (cfg_we)
            retry_limit_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= xcr_pkg::PH_IDLE;
            link_reg    <= 1'b0;
            seq_reg     <= 8'd1;
            got_seq_reg <= '0;
            retries_reg <= '0;
            long_reg    <= 1'b0;
            bc_reg      <= '0;
            crc_reg     <= '0;
            rcrc_hi_reg <= '0;
            limit_reg   <= xcr_pkg::LONG_SIZE;
        end
        else if (acc)
        begin
            phase_reg   <= phase_next;
            link_reg    <= link_next;
            seq_reg     <= seq_next;
            got_seq_reg <= got_seq_next;
            retries_reg <= retries_next;
            long_reg    <= long_next;
            bc_reg      <= bc_next;
            crc_reg     <= crc_next;
            rcrc_hi_reg <= rcrc_hi_next;
            limit_reg   <= limit_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/xmodem_crc_receiver.sv -----
`default_nettype none

// Channel | Signals                        | Carries
// --------+--------------------------------+---------------------------------------
// in      | in_valid, in_ready, in_data    | operation, rx_byte, byte_limit, index
// out     | out_valid, out_ready, out_data | tx byte, event, count, read data, last
// cfg     | cfg_valid, cfg_ready, cfg_data | retry_limit (always ready)
//
// One item per cycle while in_ready is high; its results pass through the result
// stage (framing result and packet store read) and then the output register.
// An item with two results holds the output register until both have been taken.
// Reset clears all control state; the packet store is not cleared.
// in_ready drops only when both the result stage and the output register are full.

module xmodem_crc_receiver
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire xcr_pkg::xcr_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output xcr_pkg::xcr_out_t      out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [15:0]       cfg_data
);

    logic               acc;
    xcr_pkg::xcr_act_t  act;

    logic [7:0]         store [xcr_pkg::PACKET_MAX];
    logic [7:0]         mem_q_reg;

    logic               s1_v_reg;
    xcr_pkg::xcr_rec_t  s1_rec_reg;
    logic               out_v_reg;
    logic               out_first_reg;
    xcr_pkg::xcr_rec_t  out_rec_reg;
    logic [7:0]         out_rd_reg;

    logic               out_take;
    logic               out_done;
    logic               s1_move;

    assign cfg_ready = 1'b1;
    assign acc       = in_valid && in_ready;

    assign out_take = out_v_reg && out_ready;
    assign out_done = out_take && !out_first_reg;
    assign s1_move  = s1_v_reg && (!out_v_reg || out_done);
    assign in_ready = !s1_v_reg || s1_move;

    xcr_frame u_frame
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc      (acc),
        .item     (in_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .act      (act)
    );

    // packet store: byte write from framing, read issued on the transfer itself
    always_ff @(posedge clk)
    begin
        if (act.wr_en)
            store[act.wr_addr] <= act.wr_data;
        if (acc && in_data.operation == xcr_pkg::OP_READ)
            mem_q_reg <= store[in_data.read_index];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (acc)
            s1_v_reg <= act.res_v;
        else if (s1_move)
            s1_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            s1_rec_reg <= act.rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg     <= 1'b0;
            out_first_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_v_reg     <= 1'b1;
            out_first_reg <= s1_rec_reg.dbl;
        end
        else if (out_take)
        begin
            if (out_first_reg)
                out_first_reg <= 1'b0;
            else
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_rec_reg <= s1_rec_reg;
            out_rd_reg  <= s1_rec_reg.rd_ok ? mem_q_reg : 8'h00;
        end
    end

    always_comb
    begin
        out_valid = out_v_reg;
        if (out_first_reg)
        begin
            // leading CAN of a cancel pair
            out_data.tx_valid  = 1'b1;
            out_data.tx_byte   = xcr_pkg::B_CAN;
            out_data.event_res = xcr_pkg::EV_NONE;
            out_data.count     = '0;
            out_data.read_data = '0;
            out_data.last      = 1'b0;
        end
        else
        begin
            out_data.tx_valid  = out_rec_reg.tx_valid;
            out_data.tx_byte   = out_rec_reg.tx_byte;
            out_data.event_res = out_rec_reg.event_res;
            out_data.count     = out_rec_reg.count;
            out_data.read_data = out_rd_reg;
            out_data.last      = 1'b1;
        end
    end

endmodule

`default_nettype wire
